>>> sv/ovl_pkg.sv
// ----------------------------------------------------------------------------
// ovl_pkg
// Shared types and constants of the ordered value list.
// ----------------------------------------------------------------------------
package ovl_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int COUNT_W       = 5;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic        [COUNT_W-1:0] count_field_t;

    typedef enum logic [1:0] {
        ACT_APPEND      = 2'd0,
        ACT_PREPEND     = 2'd1,
        ACT_REMOVE      = 2'd2,
        ACT_REMOVE_TAIL = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DONE
    } state_t;

    // drive of the cell row from the controller
    typedef struct packed {
        logic   shift;
        value_t feed;
    } row_ctrl_t;

endpackage

>>> sv/ovl_if.sv
// ----------------------------------------------------------------------------
// ovl_req_if / ovl_rsp_if
// Valid/ready channels for requests and results of the ordered value list.
// ----------------------------------------------------------------------------
interface ovl_req_if import ovl_pkg::*; ();
    logic    valid;
    logic    ready;
    action_t action;
    value_t  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface ovl_rsp_if import ovl_pkg::*; ();
    logic         valid;
    logic         ready;
    status_t      status;
    count_field_t entry_count;
    value_t       head_value;
    value_t       tail_value;

    modport source (output valid, output status, output entry_count,
                    output head_value, output tail_value, input ready);
    modport sink   (input valid, input status, input entry_count,
                    input head_value, input tail_value, output ready);
endinterface

>>> sv/ovl_cell.sv
// ----------------------------------------------------------------------------
// ovl_cell
// One entry of the cell row; takes its neighbour's entry on a shift.
// ----------------------------------------------------------------------------
module ovl_cell import ovl_pkg::*;
(
    input  logic   clk,
    input  logic   shift,
    input  value_t din,
    output value_t dout
);

    value_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= din;
        end
    end

    assign dout = entry_reg;

endmodule

>>> sv/ovl_ctrl.sv
// ----------------------------------------------------------------------------
// ovl_ctrl
// Request sequencer: runs one sweep round the cell row per request that is
// not refused, picks the value fed back into the row and builds the result beat.
// ----------------------------------------------------------------------------
module ovl_ctrl import ovl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    ovl_req_if.sink   req,
    ovl_rsp_if.source rsp,
    input  value_t    row_out,
    output row_ctrl_t row_ctrl
);

    localparam int KW = $clog2(DEPTH + 2);
    localparam int CW = $clog2(DEPTH + 1);

    state_t         state_reg, state_next;
    logic [KW-1:0]  step_reg, step_next;
    logic [CW-1:0]  count_reg, count_next;
    action_t        act_reg, act_next;
    value_t         val_reg, val_next;
    logic           found_reg, found_next;
    status_t        status_reg, status_next;
    value_t         dly_reg, dly2_reg;
    value_t         head_reg, head_next;
    value_t         tail_reg, tail_next;
    logic           out_valid_reg;
    status_t        out_status_reg;
    count_field_t   out_count_reg;
    value_t         out_head_reg, out_tail_reg;

    logic           req_beat;
    logic           slot_free;
    logic           refused;
    logic           match_now;
    logic           last_step;
    logic [KW-1:0]  cnt_ext;
    logic [KW-1:0]  new_cnt;
    value_t         feed;

    assign req_beat  = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign cnt_ext   = KW'(count_reg);
    assign last_step = (step_reg == KW'(DEPTH));

    always_comb
    begin
        case (req.action)
            ACT_APPEND, ACT_PREPEND: refused = (count_reg == CW'(DEPTH));
            default:                 refused = (count_reg == '0);
        endcase
    end

    // first match seen at the front of the row
    assign match_now = (act_reg == ACT_REMOVE) && !found_reg &&
                       (step_reg < cnt_ext) && (row_out == val_reg);

    always_comb
    begin
        case (act_reg)
            ACT_APPEND:      new_cnt = cnt_ext + KW'(1);
            ACT_PREPEND:     new_cnt = cnt_ext + KW'(1);
            ACT_REMOVE:      new_cnt = (found_reg || match_now) ? cnt_ext - KW'(1) : cnt_ext;
            default:         new_cnt = cnt_ext - KW'(1);
        endcase
    end

    // value fed into the far end of the row
    always_comb
    begin
        feed = dly_reg;
        case (act_reg)
            ACT_APPEND:
            begin
                if (step_reg == cnt_ext + KW'(1))
                begin
                    feed = val_reg;
                end
            end
            ACT_PREPEND:
            begin
                feed = (step_reg == KW'(1)) ? val_reg : dly2_reg;
            end
            ACT_REMOVE:
            begin
                feed = found_reg ? row_out : dly_reg;
            end
            default:
            begin
                feed = dly_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_beat)
                begin
                    state_next = refused ? S_DONE : S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (last_step)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        step_next   = step_reg;
        count_next  = count_reg;
        act_next    = act_reg;
        val_next    = val_reg;
        found_next  = found_reg;
        status_next = status_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_beat)
                begin
                    step_next  = '0;
                    act_next   = req.action;
                    val_next   = req.value;
                    found_next = 1'b0;
                    if (refused)
                    begin
                        status_next = (req.action == ACT_APPEND ||
                                       req.action == ACT_PREPEND) ? ST_FULL : ST_EMPTY;
                    end
                    else
                    begin
                        status_next = ST_DONE;
                    end
                end
            end
            S_SWEEP:
            begin
                step_next  = step_reg + KW'(1);
                found_next = found_reg || match_now;
                if (step_reg == KW'(1))
                begin
                    head_next = feed;
                end
                if (act_reg == ACT_REMOVE)
                begin
                    if (step_reg == cnt_ext - KW'(1) ||
                        (step_reg == cnt_ext && !found_reg))
                    begin
                        tail_next = feed;
                    end
                end
                else if (step_reg == new_cnt)
                begin
                    tail_next = feed;
                end
                if (last_step)
                begin
                    count_next = CW'(new_cnt);
                    if (act_reg == ACT_REMOVE && !(found_reg || match_now))
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req.ready      = (state_reg == S_IDLE);
        row_ctrl.shift = (state_reg == S_SWEEP);
        row_ctrl.feed  = feed;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.head_value  = out_head_reg;
    assign rsp.tail_value  = out_tail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            found_reg <= found_next;
            step_reg  <= step_next;
            if (state_reg == S_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        head_reg   <= head_next;
        tail_reg   <= tail_next;
        if (state_reg == S_SWEEP)
        begin
            dly_reg  <= row_out;
            dly2_reg <= dly_reg;
        end
        if (state_reg == S_DONE && slot_free)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= COUNT_W'(count_reg);
            out_head_reg   <= (count_reg == '0) ? '0 : head_reg;
            out_tail_reg   <= (count_reg == '0) ? '0 : tail_reg;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SWEEP |-> step_reg <= KW'(DEPTH))
        else $error("sweep ran past the row");

    a_found_remove: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg && state_reg == S_SWEEP |-> act_reg == ACT_REMOVE)
        else $error("match flag set outside a remove");

    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == ST_EMPTY |-> out_count_reg == '0)
        else $error("empty status with entries held");

    a_full_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == ST_FULL |-> out_count_reg == COUNT_W'(DEPTH))
        else $error("full status on a list with room");

endmodule

>>> sv/ordered_value_list_unit.sv
// ----------------------------------------------------------------------------
// ordered_value_list_unit
// Ordered list of signed values with append, prepend and removal.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells that all shift towards the front
// together, the front cell feeding back into the far end through the
// controller. A request that is not refused, including a removal that finds
// no match, runs one sweep of DEPTH+1 shifts round the row before its result
// beat is registered; a refused request (append or prepend on a full list,
// removal on an empty one) goes to its result beat without a sweep. One
// request is handled at a time; the next request beat is taken while the
// previous result still waits in the output register.
module ordered_value_list_unit import ovl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    ovl_req_if.sink   req,
    ovl_rsp_if.source rsp
);

    row_ctrl_t row_ctrl;
    value_t    cell_data [DEPTH];

    ovl_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .row_out  (cell_data[0]),
        .row_ctrl (row_ctrl)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        value_t din;
        if (i == DEPTH - 1)
        begin : g_end
            assign din = row_ctrl.feed;
        end
        else
        begin : g_mid
            assign din = cell_data[i+1];
        end

        ovl_cell u_cell (
            .clk   (clk),
            .shift (row_ctrl.shift),
            .din   (din),
            .dout  (cell_data[i])
        );
    end

endmodule
